// ===== sv/inverse_gap_force_accumulator_top_assert.svh =====
// Assertion macros used by the force accumulator engine.
`ifndef INVERSE_GAP_FORCE_ACCUMULATOR_TOP_ASSERT_SVH
`define INVERSE_GAP_FORCE_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IGFA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igfa assertion failed");

// Next-cycle implication, checked outside reset.
`define IGFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igfa assertion failed");

`endif

// ===== sv/igfa_pkg.sv =====
// Types, constants and the arctangent table of the force accumulator.
`default_nettype none
package igfa_pkg;

    typedef struct packed {
        logic        is_self;
        logic        last;
        logic        sh;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [30:0] orad;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qout_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] magnitude;
        logic [15:0] direction;
        logic        overlap;
    } res_t;

    localparam logic [1:0] REG_OWN_X      = 2'd0;
    localparam logic [1:0] REG_OWN_Y      = 2'd1;
    localparam logic [1:0] REG_OWN_RADIUS = 2'd2;

    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;
    localparam logic signed [33:0] PI_Q28  = 34'sd843314857;
    localparam logic [19:0]        PI_Q13  = 20'd25736;

    function automatic logic [27:0] atan_q28(input logic [4:0] i);
        logic [27:0] v;
        case (i)
            5'd0:  v = 28'd210828714;
            5'd1:  v = 28'd124459457;
            5'd2:  v = 28'd65760959;
            5'd3:  v = 28'd33381290;
            5'd4:  v = 28'd16755422;
            5'd5:  v = 28'd8385879;
            5'd6:  v = 28'd4193963;
            5'd7:  v = 28'd2097109;
            5'd8:  v = 28'd1048571;
            5'd9:  v = 28'd524287;
            5'd10: v = 28'd262144;
            5'd11: v = 28'd131072;
            5'd12: v = 28'd65536;
            5'd13: v = 28'd32768;
            5'd14: v = 28'd16384;
            5'd15: v = 28'd8192;
            5'd16: v = 28'd4096;
            5'd17: v = 28'd2048;
            5'd18: v = 28'd1024;
            5'd19: v = 28'd512;
            5'd20: v = 28'd256;
            5'd21: v = 28'd128;
            5'd22: v = 28'd64;
            5'd23: v = 28'd32;
            5'd24: v = 28'd16;
            5'd25: v = 28'd8;
            5'd26: v = 28'd4;
            5'd27: v = 28'd2;
            5'd28: v = 28'd1;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/igfa_front.sv =====
// Front end: accept circles, form offset magnitudes, hold them in a two-entry queue.
`default_nettype none
module igfa_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [31:0]          own_x,
    input  wire logic [31:0]          own_y,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [95:0]          s_axis_tdata,
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    output igfa_pkg::qout_t           qo,
    input  wire logic                 pop
);

    igfa_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    igfa_pkg::item_t in_item;
    logic [32:0]     dx;
    logic [32:0]     dy;
    logic [32:0]     ndx;
    logic [32:0]     ndy;
    logic            push;

    always_comb
    begin
        dx  = {s_axis_tdata[31], s_axis_tdata[31:0]} - {own_x[31], own_x};
        dy  = {s_axis_tdata[63], s_axis_tdata[63:32]} - {own_y[31], own_y};
        ndx = -dx;
        ndy = -dy;
        in_item.is_self = s_axis_tuser[0];
        in_item.last    = s_axis_tlast;
        in_item.neg_x   = dx[32];
        in_item.neg_y   = dy[32];
        in_item.ax      = dx[32] ? ndx[31:0] : dx[31:0];
        in_item.ay      = dy[32] ? ndy[31:0] : dy[31:0];
        in_item.sh      = in_item.ax[31] | in_item.ay[31];
        in_item.orad    = s_axis_tdata[94:64];
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign qo.valid      = (count_reg != 2'd0);
    assign qo.item       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/igfa_engine.sv =====
// Back end: iterative root, divider, accumulate, magnitude and vectoring CORDIC.
`default_nettype none
module igfa_engine #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire igfa_pkg::qout_t qo,
    output logic                 pop,
    input  wire logic [30:0]     own_radius,
    output igfa_pkg::res_t       res,
    input  wire logic            res_ready
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic signed [51:0] LIM45 = 52'sh2000_0000_0000;
    localparam logic [47:0] SUM_MAX_B = igfa_pkg::SUM_MAX;
    localparam logic [47:0] SUM_MIN_B = igfa_pkg::SUM_MIN;

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_SQX   = 16'b0000_0000_0000_0010,
        S_SQY   = 16'b0000_0000_0000_0100,
        S_SQS   = 16'b0000_0000_0000_1000,
        S_SQRT  = 16'b0000_0000_0001_0000,
        S_GAP   = 16'b0000_0000_0010_0000,
        S_DIV   = 16'b0000_0000_0100_0000,
        S_MULX  = 16'b0000_0000_1000_0000,
        S_MULY  = 16'b0000_0001_0000_0000,
        S_ACCY  = 16'b0000_0010_0000_0000,
        S_END   = 16'b0000_0100_0000_0000,
        S_MNORM = 16'b0000_1000_0000_0000,
        S_CNORM = 16'b0001_0000_0000_0000,
        S_CROT  = 16'b0010_0000_0000_0000,
        S_DIR   = 16'b0100_0000_0000_0000,
        S_OUT   = 16'b1000_0000_0000_0000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    igfa_pkg::item_t        cur_reg;
    logic                   mode_reg;
    logic [5:0]             cnt_reg;
    logic [63:0]            prod_reg;
    logic [63:0]            nsum_reg;
    logic [63:0]            sq_n_reg;
    logic [34:0]            sq_rem_reg;
    logic [31:0]            sq_root_reg;
    logic [32:0]            dist_reg;
    logic [33:0]            den_reg;
    logic [33:0]            drem_reg;
    logic [48:0]            dn_reg;
    logic [32:0]            q_reg;
    logic [1:0]             dsel_reg;
    logic [32:0]            inv_reg;
    logic [16:0]            ux_reg;
    logic [16:0]            uy_reg;
    logic signed [47:0]     sum_x_reg;
    logic signed [47:0]     sum_y_reg;
    logic                   ovl_reg;
    logic [47:0]            ma_reg;
    logic [47:0]            mb_reg;
    logic [4:0]             shc_reg;
    logic [31:0]            mag_reg;
    logic                   ovl_out_reg;
    logic [15:0]            dir_reg;
    logic signed [51:0]     cx_reg;
    logic signed [51:0]     cy_reg;
    logic signed [33:0]     cz_reg;
    logic [CW-1:0]          ci_reg;

    logic [30:0]            hx;
    logic [30:0]            hy;
    logic [30:0]            mul_a;
    logic [32:0]            mul_b;
    logic [63:0]            mul_p;
    logic [34:0]            sq_rem2;
    logic [34:0]            sq_t;
    logic                   sq_ge;
    logic [34:0]            sq_diff;
    logic [31:0]            sq_root_nx;
    logic [32:0]            dist_nx;
    logic [48:0]            mag_w;
    logic [31:0]            mag_sat;
    logic [34:0]            d_t;
    logic                   d_ge;
    logic [34:0]            d_diff;
    logic [33:0]            d_rem_nx;
    logic [32:0]            q_nx;
    logic signed [34:0]     gap_w;
    logic                   gap_pos;
    logic [47:0]            abs_sx;
    logic [47:0]            abs_sy;
    logic signed [51:0]     c_xs;
    logic signed [51:0]     c_ys;
    logic signed [33:0]     c_at;
    logic                   c_small;
    logic [33:0]            az;
    logic [19:0]            qz;
    logic [15:0]            qzc;
    logic                   cz_done;

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
                                                   input logic [47:0] m,
                                                   input logic neg);
        logic signed [49:0] t;
        logic signed [49:0] mv;
        mv = $signed({2'b00, m});
        t  = $signed({{2{s[47]}}, s}) + (neg ? -mv : mv);
        if (t > $signed({{2{SUM_MAX_B[47]}}, SUM_MAX_B}))
        begin
            return igfa_pkg::SUM_MAX;
        end
        if (t < $signed({{2{SUM_MIN_B[47]}}, SUM_MIN_B}))
        begin
            return igfa_pkg::SUM_MIN;
        end
        return t[47:0];
    endfunction

    // Shared operand selection for the single multiplier.
    always_comb
    begin
        hx = cur_reg.sh ? cur_reg.ax[31:1] : cur_reg.ax[30:0];
        hy = cur_reg.sh ? cur_reg.ay[31:1] : cur_reg.ay[30:0];
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:
            begin
                mul_a = mode_reg ? ma_reg[30:0] : hx;
                mul_b = {2'b00, mul_a};
            end
            S_SQY:
            begin
                mul_a = mode_reg ? mb_reg[30:0] : hy;
                mul_b = {2'b00, mul_a};
            end
            S_MULX:
            begin
                mul_a = {14'd0, ux_reg};
                mul_b = inv_reg;
            end
            S_MULY:
            begin
                mul_a = {14'd0, uy_reg};
                mul_b = inv_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {33'd0, mul_a} * {31'd0, mul_b};
    end

    // One root bit, one quotient bit and one CORDIC step per cycle.
    always_comb
    begin
        sq_rem2    = {sq_rem_reg[32:0], sq_n_reg[63:62]};
        sq_t       = {1'b0, sq_root_reg, 2'b01};
        sq_ge      = (sq_rem2 >= sq_t);
        sq_diff    = sq_rem2 - sq_t;
        sq_root_nx = {sq_root_reg[30:0], sq_ge};
        dist_nx    = cur_reg.sh ? {sq_root_nx, 1'b0} : {1'b0, sq_root_nx};
        mag_w      = {17'd0, sq_root_nx} << shc_reg;
        mag_sat    = (mag_w[48:32] != '0) ? 32'hFFFF_FFFF : mag_w[31:0];

        d_t      = {drem_reg, dn_reg[48]};
        d_ge     = (d_t >= {1'b0, den_reg});
        d_diff   = d_t - {1'b0, den_reg};
        d_rem_nx = d_ge ? d_diff[33:0] : d_t[33:0];
        q_nx     = {q_reg[31:0], d_ge};

        gap_w   = $signed({2'b00, dist_reg}) - $signed({4'b0000, own_radius})
                - $signed({4'b0000, cur_reg.orad});
        gap_pos = !gap_w[34] && (gap_w != '0);

        abs_sx = sum_x_reg[47] ? 48'(-sum_x_reg) : 48'(sum_x_reg);
        abs_sy = sum_y_reg[47] ? 48'(-sum_y_reg) : 48'(sum_y_reg);

        c_xs    = cx_reg >>> ci_reg;
        c_ys    = cy_reg >>> ci_reg;
        c_at    = $signed({6'd0, igfa_pkg::atan_q28(5'(ci_reg))});
        c_small = (cx_reg < LIM45) && (cx_reg > -LIM45)
               && (cy_reg < LIM45) && (cy_reg > -LIM45);
        cz_done = (ci_reg == CW'(CORDIC_STEPS - 1));

        az  = cz_reg[33] ? 34'(-cz_reg) : 34'(cz_reg);
        qz  = 20'((35'(az) + 35'd16384) >> 15);
        qzc = (qz > igfa_pkg::PI_Q13) ? 16'(igfa_pkg::PI_Q13) : qz[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (qo.valid) state_next = qo.item.is_self ? S_END : S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_SQS;
            S_SQS:   state_next = S_SQRT;
            S_SQRT:
            begin
                if (cnt_reg == 6'd1)
                begin
                    if (!mode_reg)
                    begin
                        state_next = S_GAP;
                    end
                    else
                    begin
                        state_next = (cx_reg == '0 && cy_reg == '0) ? S_OUT : S_CNORM;
                    end
                end
            end
            S_GAP:   state_next = gap_pos ? S_DIV : S_END;
            S_DIV:   if (cnt_reg == 6'd1 && dsel_reg == 2'd2) state_next = S_MULX;
            S_MULX:  state_next = S_MULY;
            S_MULY:  state_next = S_ACCY;
            S_ACCY:  state_next = S_END;
            S_END:   state_next = cur_reg.last ? S_MNORM : S_IDLE;
            S_MNORM:
            begin
                if (ma_reg[47:31] == '0 && mb_reg[47:31] == '0)
                begin
                    state_next = S_SQX;
                end
            end
            S_CNORM: if (!c_small) state_next = S_CROT;
            S_CROT:  if (cz_done) state_next = S_DIR;
            S_DIR:   state_next = S_OUT;
            S_OUT:   if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign pop           = (state_reg == S_IDLE) && qo.valid;
    assign res.valid     = (state_reg == S_OUT);
    assign res.magnitude = mag_reg;
    assign res.direction = dir_reg;
    assign res.overlap   = ovl_out_reg;

    // Control and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            ovl_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_GAP:  if (!gap_pos) ovl_reg <= 1'b1;
                S_MULY: sum_x_reg <= sat_add(sum_x_reg, prod_reg[63:16], cur_reg.neg_x);
                S_ACCY: sum_y_reg <= sat_add(sum_y_reg, prod_reg[63:16], cur_reg.neg_y);
                S_END:
                begin
                    if (cur_reg.last)
                    begin
                        sum_x_reg <= '0;
                        sum_y_reg <= '0;
                        ovl_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                cur_reg  <= qo.item;
                mode_reg <= 1'b0;
            end
            S_SQY:   nsum_reg <= prod_reg;
            S_SQS:
            begin
                sq_n_reg    <= nsum_reg + prod_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                cnt_reg     <= 6'd32;
            end
            S_SQRT:
            begin
                sq_n_reg    <= {sq_n_reg[61:0], 2'b00};
                sq_rem_reg  <= sq_ge ? sq_diff : sq_rem2;
                sq_root_reg <= sq_root_nx;
                cnt_reg     <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    dist_reg <= dist_nx;
                    mag_reg  <= mag_sat;
                    dir_reg  <= '0;
                end
            end
            S_GAP:
            begin
                den_reg  <= gap_w[33:0];
                drem_reg <= '0;
                dn_reg   <= {1'b1, 48'd0};
                q_reg    <= '0;
                cnt_reg  <= 6'd33;
                dsel_reg <= 2'd0;
            end
            S_DIV:
            begin
                drem_reg <= d_rem_nx;
                dn_reg   <= {dn_reg[47:0], 1'b0};
                q_reg    <= q_nx;
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    // Hand the divider on to the next quotient of this item.
                    den_reg <= {1'b0, dist_reg};
                    q_reg   <= '0;
                    cnt_reg <= 6'd17;
                    case (dsel_reg)
                        2'd0:
                        begin
                            inv_reg  <= q_nx;
                            drem_reg <= {3'd0, cur_reg.ax[31:1]};
                            dn_reg   <= {cur_reg.ax[0], 48'd0};
                            dsel_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            ux_reg   <= q_nx[16:0];
                            drem_reg <= {3'd0, cur_reg.ay[31:1]};
                            dn_reg   <= {cur_reg.ay[0], 48'd0};
                            dsel_reg <= 2'd2;
                        end
                        default:
                        begin
                            uy_reg <= q_nx[16:0];
                        end
                    endcase
                end
            end
            S_END:
            begin
                ma_reg      <= abs_sx;
                mb_reg      <= abs_sy;
                shc_reg     <= '0;
                cx_reg      <= 52'(sum_x_reg);
                cy_reg      <= 52'(sum_y_reg);
                ovl_out_reg <= ovl_reg;
                mode_reg    <= 1'b1;
            end
            S_MNORM:
            begin
                if (ma_reg[47:31] != '0 || mb_reg[47:31] != '0)
                begin
                    ma_reg  <= ma_reg >> 1;
                    mb_reg  <= mb_reg >> 1;
                    shc_reg <= shc_reg + 5'd1;
                end
            end
            S_CNORM:
            begin
                ci_reg <= '0;
                if (c_small)
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
                else if (cx_reg < 0)
                begin
                    cz_reg <= (cy_reg >= 0) ? igfa_pkg::PI_Q28 : -igfa_pkg::PI_Q28;
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
                else
                begin
                    cz_reg <= '0;
                end
            end
            S_CROT:
            begin
                ci_reg <= ci_reg + CW'(1);
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + c_ys;
                    cy_reg <= cy_reg - c_xs;
                    cz_reg <= cz_reg + c_at;
                end
                else
                begin
                    cx_reg <= cx_reg - c_ys;
                    cy_reg <= cy_reg + c_xs;
                    cz_reg <= cz_reg - c_at;
                end
            end
            S_DIR:   dir_reg <= cz_reg[33] ? -qzc : qzc;
            default: ;
        endcase
    end

`include "inverse_gap_force_accumulator_top_assert.svh"

    `IGFA_ASSERT_IMPLIES(a_div_den_nonzero, state_reg == S_DIV, den_reg != '0)
    `IGFA_ASSERT_IMPLIES(a_pop_has_item, pop, qo.valid && (state_reg == S_IDLE))
    `IGFA_ASSERT_NEXT(a_set_clears_sums, (state_reg == S_END) && cur_reg.last, (sum_x_reg == '0) && (sum_y_reg == '0) && !ovl_reg)

endmodule
`default_nettype wire

// ===== sv/inverse_gap_force_accumulator_top.sv =====
// Top level of the inverse-gap force accumulator: config registers, front, engine, output.
//
//  channel   | dir | transaction contents (low bit first)
//  ----------+-----+-----------------------------------------------------------
//  cfg       | in  | cfg_index selects own_x / own_y / own_radius, cfg_data value
//  s_axis    | in  | tdata other_x, other_y, other_radius; tuser is_self; tlast
//  m_axis    | out | tdata magnitude, direction; tuser overlap_seen
//
//  A circle that adds a term passes in the back end through the bit-serial square
//  root of 32 bits, the one-bit-per-cycle divider for a 33-bit and two 17-bit
//  quotients, and the squares, products and accumulation. A self item goes straight
//  to the end state. The last item adds up to 17 range shifts, a second root, up
//  to 45 normalizing doublings and CORDIC_STEPS rotations. rst_n clears sums and control.
//  A two-entry queue lets the front accept while the engine works; a held
//  result waits in the output register while the engine moves on.
`default_nettype none
module inverse_gap_force_accumulator_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // other_x[31:0], other_y[63:32], other_radius[94:64]
    input  wire logic [0:0]  s_axis_tuser,   // is_self[0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // magnitude[31:0], direction[47:32]
    output logic [0:0]       m_axis_tuser    // overlap_seen[0]
);

    logic [31:0]     own_x_reg;
    logic [31:0]     own_y_reg;
    logic [30:0]     own_r_reg;
    igfa_pkg::qout_t qo;
    igfa_pkg::res_t  res;
    logic            pop;
    logic            res_ready;
    logic            m_valid_reg;
    logic [47:0]     m_data_reg;
    logic [0:0]      m_user_reg;

    // Register writes; an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_x_reg <= '0;
            own_y_reg <= '0;
            own_r_reg <= 31'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                igfa_pkg::REG_OWN_X:      own_x_reg <= cfg_data;
                igfa_pkg::REG_OWN_Y:      own_y_reg <= cfg_data;
                igfa_pkg::REG_OWN_RADIUS: own_r_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    igfa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .own_x         (own_x_reg),
        .own_y         (own_y_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .qo            (qo),
        .pop           (pop)
    );

    igfa_engine #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .qo         (qo),
        .pop        (pop),
        .own_radius (own_r_reg),
        .res        (res),
        .res_ready  (res_ready)
    );

    // Output register: load a result when the slot is empty or being drained.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            m_data_reg <= {res.direction, res.magnitude};
            m_user_reg <= res.overlap;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
`default_nettype wire
